[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds through reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/rcdgp_pkg.sv]
// ----------------------------------------------------------------------------
// rcdgp_pkg
// Types, codes and constants of the cost grid painter.
// ----------------------------------------------------------------------------
`default_nettype none

package rcdgp_pkg;

    localparam int DEF_GRID_WIDTH  = 128;
    localparam int DEF_GRID_HEIGHT = 128;
    localparam int COUNT_MAX       = 32767;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;

    localparam logic signed [7:0] CELL_UNKNOWN = -8'sd1;
    localparam logic        [6:0] COST_CEIL    = 7'd100;

    typedef enum logic [1:0] {
        OP_FILL  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_MARK  = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UNKNOWN_VALUE = 3'd0,
        CFG_FREE_VALUE    = 3'd1,
        CFG_MIN_COST      = 3'd2,
        CFG_MAX_COST      = 3'd3,
        CFG_KNEE_LOW      = 3'd4,
        CFG_KNEE_HIGH     = 3'd5,
        CFG_HIT_RADIUS    = 3'd6,
        CFG_CLEAR_RADIUS  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        t_op                operation;
        logic signed [11:0] center_x;
        logic signed [11:0] center_y;
        logic        [15:0] range_mm;
    } t_in;

    typedef struct packed {
        logic signed [7:0]  cell_value;
        logic        [6:0]  cost_used;
        logic        [14:0] cells_written;
    } t_out;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_COST,
        ST_DISK,
        ST_DRAIN,
        ST_READ,
        ST_CAPTURE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic sweep_clear;
        logic sweep_fill;
        logic disk_init;
        logic disk_mark;
        logic disk_step;
        logic read_capture;
        logic finish;
    } t_cmd;

    typedef struct packed {
        t_op  in_op;
        logic clear_zero;
        logic sweep_last;
        logic disk_last;
        logic cost_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

[rtl/rcdgp_cost.sv]
// ----------------------------------------------------------------------------
// rcdgp_cost
// Range to cost mapping: knee clamps, then rounded linear interpolation by a
// restoring divider that resolves one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rcdgp_cost (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_range_mm,
    input  logic [15:0] i_knee_lo,
    input  logic [15:0] i_knee_hi,
    input  logic [6:0]  i_min_cost,
    input  logic [6:0]  i_max_cost,
    output logic        o_done,
    output logic [6:0]  o_cost
);
    import rcdgp_pkg::*;

    localparam logic [3:0] STEP_IDLE = 4'd0;
    localparam logic [3:0] STEP_DIFF = 4'd1;
    localparam logic [3:0] STEP_MUL  = 4'd2;
    localparam logic [3:0] STEP_SUM  = 4'd3;
    localparam logic [3:0] STEP_DIVN = 4'd10;
    localparam logic [3:0] STEP_DONE = 4'd11;

    logic [3:0]  r_step;
    logic [15:0] r_lo;
    logic [16:0] r_hi;
    logic [15:0] r_rng;
    logic [6:0]  r_cmin;
    logic [6:0]  r_cmax;
    logic        r_le;
    logic        r_ge;
    logic [16:0] r_a;
    logic [16:0] r_b;
    logic [16:0] r_d;
    logic [23:0] r_pa;
    logic [23:0] r_pb;
    logic [24:0] r_rem;
    logic [24:0] r_dsh;
    logic [6:0]  r_q;

    logic [24:0] num;

    assign num    = 25'(r_pa) + 25'(r_pb);
    assign o_done = (r_step == STEP_DONE);
    assign o_cost = r_le ? r_cmax : (r_ge ? r_cmin : r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else if (r_step == STEP_IDLE) begin
            if (i_start) begin
                r_step <= STEP_DIFF;
            end
        end else if (r_step == STEP_DONE) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= r_step + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_step == STEP_IDLE) begin
            r_lo   <= i_knee_lo;
            r_rng  <= i_range_mm;
            // upper knee sits at least 1 mm above the lower one
            r_hi   <= (i_knee_hi > i_knee_lo) ? {1'b0, i_knee_hi}
                                              : {1'b0, i_knee_lo} + 17'd1;
            r_cmin <= (i_min_cost > COST_CEIL) ? COST_CEIL : i_min_cost;
            r_cmax <= (i_max_cost > COST_CEIL) ? COST_CEIL : i_max_cost;
        end
        if (r_step == STEP_DIFF) begin
            r_le <= (r_rng <= r_lo);
            r_ge <= ({1'b0, r_rng} >= r_hi);
            r_a  <= {1'b0, r_rng} - {1'b0, r_lo};
            r_b  <= r_hi - {1'b0, r_rng};
            r_d  <= r_hi - {1'b0, r_lo};
        end
        if (r_step == STEP_MUL) begin
            r_pa <= 24'(r_cmin) * 24'(r_a);
            r_pb <= 24'(r_cmax) * 24'(r_b);
        end
        if (r_step == STEP_SUM) begin
            // (2*num + d) / (2*d): quotient never exceeds 100
            r_rem <= (num << 1) + 25'(r_d);
            r_dsh <= {1'b0, r_d, 7'b0};
            r_q   <= '0;
        end
        if (r_step > STEP_SUM && r_step <= STEP_DIVN) begin
            if (r_rem >= r_dsh) begin
                r_rem <= r_rem - r_dsh;
                r_q   <= {r_q[5:0], 1'b1};
            end else begin
                r_q   <= {r_q[5:0], 1'b0};
            end
            r_dsh <= r_dsh >> 1;
        end
    end

endmodule

`default_nettype wire

[rtl/rcdgp_dpath.sv]
// ----------------------------------------------------------------------------
// rcdgp_dpath
// Settings, grid store, sweep counter, disk walker with a read-modify-write
// stage, cost unit and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rcdgp_dpath #(
    parameter int GRID_WIDTH  = rcdgp_pkg::DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = rcdgp_pkg::DEF_GRID_HEIGHT
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  rcdgp_pkg::t_in                        i_in_data,
    input  logic                                  i_cfg_valid,
    input  logic [rcdgp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rcdgp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                  i_out_ready,
    input  rcdgp_pkg::t_cmd                       i_cmd,
    output rcdgp_pkg::t_sts                       o_sts,
    output logic                                  o_out_valid,
    output rcdgp_pkg::t_out                       o_out_data
);
    import rcdgp_pkg::*;

    localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(GRID_WIDTH);
    localparam int ROW_W  = $clog2(GRID_HEIGHT);
    localparam logic [14:0]       FILL_COUNT = 15'((CELLS > COUNT_MAX) ? COUNT_MAX : CELLS);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(CELLS - 1);

    // settings
    logic signed [7:0] r_unknown;
    logic signed [7:0] r_free;
    logic [6:0]        r_cmin;
    logic [6:0]        r_cmax;
    logic [15:0]       r_knee_lo;
    logic [15:0]       r_knee_hi;
    logic [3:0]        r_hit_rad;
    logic [3:0]        r_clr_rad;

    // item
    logic signed [11:0] r_cx;
    logic signed [11:0] r_cy;
    logic signed [7:0]  r_fill_val;
    logic               r_mark;

    // walker
    logic signed [4:0]  r_dx;
    logic signed [4:0]  r_dy;
    logic signed [4:0]  r_rad;
    logic [7:0]         r_rsq;
    logic [ADDR_W-1:0]  r_addr;

    // write stage
    logic               r_s1_valid;
    logic               r_s1_grid;
    logic [ADDR_W-1:0]  r_s1_addr;
    logic signed [7:0]  r_rdata;
    logic signed [7:0]  r_mem [CELLS];

    // result
    logic signed [7:0]  r_cell;
    logic [6:0]         r_cost;
    logic [14:0]        r_count;
    logic               r_out_valid;
    t_out               r_out;

    logic               fill_ok;
    logic [3:0]         disk_rad;
    logic signed [4:0]  disk_rad_s;
    logic [3:0]         abs_dx;
    logic [3:0]         abs_dy;
    logic [8:0]         rsq_sum;
    logic               in_disk;
    logic [12:0]        gx;
    logic [12:0]        gy;
    logic               in_grid;
    logic [ADDR_W-1:0]  addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic signed [7:0]  wr_data;
    logic signed [7:0]  cost_s;
    logic               cost_start;
    logic               cost_done;
    logic [6:0]         cost_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unknown <= -8'sd1;
            r_free    <= 8'sd0;
            r_cmin    <= 7'd85;
            r_cmax    <= 7'd100;
            r_knee_lo <= 16'd300;
            r_knee_hi <= 16'd2000;
            r_hit_rad <= 4'd3;
            r_clr_rad <= 4'd5;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_UNKNOWN_VALUE: r_unknown <= i_cfg_data[7:0];
                CFG_FREE_VALUE:    r_free    <= i_cfg_data[7:0];
                CFG_MIN_COST:      r_cmin    <= i_cfg_data[6:0];
                CFG_MAX_COST:      r_cmax    <= i_cfg_data[6:0];
                CFG_KNEE_LOW:      r_knee_lo <= i_cfg_data;
                CFG_KNEE_HIGH:     r_knee_hi <= i_cfg_data;
                CFG_HIT_RADIUS:    r_hit_rad <= i_cfg_data[3:0];
                CFG_CLEAR_RADIUS:  r_clr_rad <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // out-of-range unknown value falls back to the free value
    assign fill_ok    = r_unknown inside {[-8'sd1:8'sd100]};
    assign disk_rad   = i_cmd.disk_mark ? r_hit_rad : r_clr_rad;
    assign disk_rad_s = {1'b0, disk_rad};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx       <= i_in_data.center_x;
            r_cy       <= i_in_data.center_y;
            r_fill_val <= fill_ok ? r_unknown : r_free;
        end
        if (i_cmd.disk_init) begin
            r_dx   <= -disk_rad_s;
            r_dy   <= -disk_rad_s;
            r_rad  <= disk_rad_s;
            r_rsq  <= 8'(disk_rad) * 8'(disk_rad);
            r_mark <= i_cmd.disk_mark;
        end else if (i_cmd.load) begin
            r_dx <= '0;
            r_dy <= '0;
        end else if (i_cmd.disk_step) begin
            if (r_dx == r_rad) begin
                r_dx <= -r_rad;
                r_dy <= r_dy + 5'sd1;
            end else begin
                r_dx <= r_dx + 5'sd1;
            end
        end
    end

    // cell under the walker
    assign abs_dx  = r_dx[4] ? 4'(-r_dx) : r_dx[3:0];
    assign abs_dy  = r_dy[4] ? 4'(-r_dy) : r_dy[3:0];
    assign rsq_sum = 9'(8'(abs_dx) * 8'(abs_dx)) + 9'(8'(abs_dy) * 8'(abs_dy));
    assign in_disk = (rsq_sum <= {1'b0, r_rsq});
    assign gx      = {r_cx[11], r_cx} + {{8{r_dx[4]}}, r_dx};
    assign gy      = {r_cy[11], r_cy} + {{8{r_dy[4]}}, r_dy};
    assign in_grid = !gx[12] && !gy[12]
                     && (gx < 13'(GRID_WIDTH)) && (gy < 13'(GRID_HEIGHT));
    assign addr    = ADDR_W'(gy[ROW_W-1:0]) * ADDR_W'(GRID_WIDTH)
                     + ADDR_W'(gx[COL_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.disk_step && in_disk && in_grid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= addr;
        r_s1_grid <= in_grid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_cmd.sweep_clear || i_cmd.sweep_fill) begin
            r_addr <= (r_addr == LAST_ADDR) ? '0 : r_addr + 1'b1;
        end
    end

    // write side: sweeps or the disk write stage, never both at once
    assign cost_s  = {1'b0, r_cost};
    assign wr_en   = i_cmd.sweep_clear || i_cmd.sweep_fill || r_s1_valid;
    assign wr_addr = r_s1_valid ? r_s1_addr : r_addr;

    always_comb begin
        if (r_s1_valid) begin
            if (r_mark) begin
                wr_data = (r_rdata < cost_s) ? cost_s : r_rdata;
            end else begin
                wr_data = r_free;
            end
        end else if (i_cmd.sweep_fill) begin
            wr_data = r_fill_val;
        end else begin
            wr_data = CELL_UNKNOWN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[addr];
    end

    assign cost_start = i_cmd.load && (i_in_data.operation == OP_MARK);

    rcdgp_cost u_cost (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (cost_start),
        .i_range_mm (i_in_data.range_mm),
        .i_knee_lo  (r_knee_lo),
        .i_knee_hi  (r_knee_hi),
        .i_min_cost (r_cmin),
        .i_max_cost (r_cmax),
        .o_done     (cost_done),
        .o_cost     (cost_val)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cell  <= 8'sd0;
            r_cost  <= '0;
            r_count <= (i_in_data.operation == OP_FILL) ? FILL_COUNT : '0;
        end else begin
            if (cost_done) begin
                r_cost <= cost_val;
            end
            if (r_s1_valid) begin
                r_count <= r_count + 15'd1;
            end
            if (i_cmd.read_capture) begin
                r_cell <= r_s1_grid ? r_rdata : CELL_UNKNOWN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.cell_value    <= r_cell;
            r_out.cost_used     <= r_cost;
            r_out.cells_written <= r_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_sts.in_op      = i_in_data.operation;
    assign o_sts.clear_zero = (r_clr_rad == 4'd0);
    assign o_sts.sweep_last = (r_addr == LAST_ADDR);
    assign o_sts.disk_last  = (r_dx == r_rad) && (r_dy == r_rad);
    assign o_sts.cost_done  = cost_done;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

[rtl/rcdgp_ctrl.sv]
// ----------------------------------------------------------------------------
// rcdgp_ctrl
// Command sequencer: reset sweep, fill, disk walk, read and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module rcdgp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  rcdgp_pkg::t_sts i_sts,
    output logic            o_in_ready,
    output rcdgp_pkg::t_cmd o_cmd
);
    import rcdgp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.sweep_clear = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_sts.in_op)
                        OP_FILL:  n_state = ST_FILL;
                        OP_CLEAR: begin
                            if (i_sts.clear_zero) begin
                                n_state = ST_DONE;
                            end else begin
                                o_cmd.disk_init = 1'b1;
                                n_state         = ST_DISK;
                            end
                        end
                        OP_MARK:  n_state = ST_COST;
                        OP_READ:  n_state = ST_READ;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_FILL: begin
                o_cmd.sweep_fill = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_COST: begin
                if (i_sts.cost_done) begin
                    o_cmd.disk_init = 1'b1;
                    o_cmd.disk_mark = 1'b1;
                    n_state         = ST_DISK;
                end
            end
            ST_DISK: begin
                o_cmd.disk_step = 1'b1;
                if (i_sts.disk_last) begin
                    n_state = ST_DRAIN;
                end
            end
            // last write of the disk lands here
            ST_DRAIN:   n_state = ST_DONE;
            ST_READ:    n_state = ST_CAPTURE;
            ST_CAPTURE: begin
                o_cmd.read_capture = 1'b1;
                n_state            = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

[rtl/range_cost_disk_grid_painter_unit.sv]
// ----------------------------------------------------------------------------
// range_cost_disk_grid_painter_unit
// Cost grid painter: fill, ego clear disk, mark hit disk and cell read.
//
// Input channel (i_in_valid / o_in_ready, i_in_data) takes one command item;
// the output channel (o_out_valid / i_out_ready, o_out_data) returns exactly
// one result item per command. Settings are written through the cfg channel
// (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data), always ready; the user must change them
// only while the block is idle, as the block itself does not enforce this.
// The grid store has a single write port and takes one cell per cycle. A fill sweeps
// every cell; an ego clear walks the (2r+1)^2 square around the center, or is skipped
// when the clear radius is 0; a mark hit first waits for the range to cost unit, then
// walks its own (2r+1)^2 square; a read looks up a single cell.
// One item is worked on at a time. A finished result sits in the output
// register; the next item is accepted while it waits, and its own result is
// held back until the receiver has taken the earlier one.
// After reset every cell of the grid is swept to unknown (-1) while o_in_ready is
// low; settings writes are taken during the sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module range_cost_disk_grid_painter_unit #(
    parameter int GRID_WIDTH  = rcdgp_pkg::DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = rcdgp_pkg::DEF_GRID_HEIGHT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  rcdgp_pkg::t_in                   i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output rcdgp_pkg::t_out                  o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rcdgp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rcdgp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rcdgp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    rcdgp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    rcdgp_dpath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

[rtl/rcdgp_checker.sv]
// ----------------------------------------------------------------------------
// rcdgp_checker
// Port-level checks of the cost grid painter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rcdgp_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input rcdgp_pkg::t_out                  o_out_data
);
    import rcdgp_pkg::*;

    // grid sweep follows reset, so nothing is taken or offered just after it
    `ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_in_ready && !o_out_valid, "busy after reset")

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid, "result dropped")

    // one command in work at a time
    `ASSERT_CLK(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready, "second item taken")

    `ASSERT_CLK(a_cost_cap, i_clk, i_rst_n, o_out_valid |-> o_out_data.cost_used <= COST_CEIL, "cost above cap")

    // a read writes nothing, every other command reports a zero cell value
    `ASSERT_CLK(a_read_excl, i_clk, i_rst_n, o_out_valid |-> o_out_data.cell_value == 8'sd0 || o_out_data.cells_written == 15'd0, "read and write mixed")

endmodule

bind range_cost_disk_grid_painter_unit rcdgp_checker u_rcdgp_checker (.*);

`default_nettype wire
